### rtl/npec_pkg.sv
// Package with status codes and shared types for the NAND page ECC corrector.
`timescale 1ns / 1ps

package npec_pkg;

    localparam int ECC_W    = 32;
    localparam int STAT_W   = 3;
    localparam int OFFS_W   = 11;
    localparam int BIT_W    = 3;
    localparam int VERD_W   = 2;
    localparam int LOC_W    = 9;
    localparam int HALF_W   = 12;

    localparam logic [ECC_W-1:0] SYND_MASK = 32'h0FFF_0FFF;

    localparam logic [STAT_W-1:0] ST_MATCH   = 3'd0;
    localparam logic [STAT_W-1:0] ST_ECC_ERR = 3'd1;
    localparam logic [STAT_W-1:0] ST_FIXED   = 3'd2;
    localparam logic [STAT_W-1:0] ST_UNCORR  = 3'd3;
    localparam logic [STAT_W-1:0] ST_SKIPPED = 3'd4;

    localparam logic [VERD_W-1:0] PV_CLEAN  = 2'd0;
    localparam logic [VERD_W-1:0] PV_RETRY  = 2'd1;
    localparam logic [VERD_W-1:0] PV_UNCORR = 2'd2;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [LOC_W-1:0]  loc;
        logic [BIT_W-1:0]  bit_idx;
    } synd_res_t;

endpackage

### rtl/npec_syndrome.sv
// Syndrome decode: classify one chunk's ECC word pair and locate the bad bit.
`timescale 1ns / 1ps

module npec_syndrome
    import npec_pkg::*;
(
    input  logic [ECC_W-1:0] computed_ecc,
    input  logic [ECC_W-1:0] stored_ecc,
    input  logic             aborted,
    output synd_res_t        res
);

    logic [ECC_W-1:0] diff;
    logic [ECC_W-1:0] synd;
    logic             at_most_one;
    logic             complement;

    assign diff        = computed_ecc ^ stored_ecc;
    assign synd        = {diff[7:0], diff[15:8], diff[23:16], diff[31:24]} & SYND_MASK;
    assign at_most_one = ((synd - ECC_W'(1)) & synd) == '0;
    assign complement  = (synd[HALF_W-1:0] ^ synd[16 +: HALF_W]) == {HALF_W{1'b1}};

    always_comb begin
        res.status  = ST_MATCH;
        res.loc     = '0;
        res.bit_idx = '0;
        if (aborted) begin
            res.status = ST_SKIPPED;
        end else if (diff != '0) begin
            if (at_most_one) begin
                res.status = ST_ECC_ERR;
            end else if (!complement) begin
                res.status = ST_UNCORR;
            end else begin
                res.status  = ST_FIXED;
                res.loc     = synd[27:19];
                res.bit_idx = synd[18:16];
            end
        end
    end

endmodule

### rtl/nand_page_ecc_corrector.sv
// Top level of the NAND page ECC corrector: request stages, page state and result register.
// Each request is held in the input register, then in the result register.
// Throughput: one chunk request per cycle unless m_tready stalls; decode is combinational.
// The input stage keeps accepting while a finished result waits, up to one held request.
// Reset (aresetn low, synchronous) empties both stages and clears chunk count and verdict.
`timescale 1ns / 1ps

module nand_page_ecc_corrector
    import npec_pkg::*;
#(
    parameter int MAX_CHUNKS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // [31:0] computed_ecc, [63:32] stored_ecc
    input  logic        s_tlast,  // last_chunk
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // [10:0] byte_offset, [13:11] bit_index, [15:14] page_status
    output logic [2:0]  m_tuser,  // [2:0] chunk_status
    output logic        m_tlast   // page_done
);

    localparam int CW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam logic [CW:0] MAX_C = (CW+1)'(MAX_CHUNKS);

    logic             in_valid_reg;
    logic [ECC_W-1:0] calc_reg;
    logic [ECC_W-1:0] stored_reg;
    logic             last_reg;

    logic [CW-1:0]     chunk_reg;
    logic [CW-1:0]     chunk_next;
    logic [VERD_W-1:0] verdict_reg;
    logic [VERD_W-1:0] verdict_upd;
    logic [VERD_W-1:0] verdict_next;

    logic              out_valid_reg;
    logic [STAT_W-1:0] status_reg;
    logic [OFFS_W-1:0] offset_reg;
    logic [BIT_W-1:0]  bit_reg;
    logic [VERD_W-1:0] pstat_reg;
    logic              done_reg;

    logic              out_ready;
    logic              advance;
    synd_res_t         sres;
    logic [31:0]       offset_wide;
    logic [OFFS_W-1:0] offset_calc;
    logic [CW:0]       chunk_inc;

    assign out_ready = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;

    npec_syndrome u_synd (
        .computed_ecc (calc_reg),
        .stored_ecc   (stored_reg),
        .aborted      (verdict_reg == PV_UNCORR),
        .res          (sres)
    );

    assign offset_wide = 32'(sres.loc) + (32'(chunk_reg) << LOC_W);
    assign offset_calc = (sres.status == ST_FIXED) ? offset_wide[OFFS_W-1:0] : '0;
    assign chunk_inc   = {1'b0, chunk_reg} + (CW+1)'(1);

    always_comb begin
        verdict_upd = verdict_reg;
        case (sres.status)
            ST_ECC_ERR, ST_FIXED: begin
                if (verdict_reg == PV_CLEAN) begin
                    verdict_upd = PV_RETRY;
                end
            end
            ST_UNCORR: begin
                verdict_upd = PV_UNCORR;
            end
            default: begin
                verdict_upd = verdict_reg;
            end
        endcase
    end

    always_comb begin
        if (last_reg) begin
            chunk_next   = '0;
            verdict_next = PV_CLEAN;
        end else begin
            verdict_next = verdict_upd;
            if (chunk_inc < MAX_C) begin
                chunk_next = chunk_inc[CW-1:0];
            end else begin
                chunk_next = chunk_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            chunk_reg     <= '0;
            verdict_reg   <= PV_CLEAN;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_ready) begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance) begin
                chunk_reg   <= chunk_next;
                verdict_reg <= verdict_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            calc_reg   <= s_tdata[31:0];
            stored_reg <= s_tdata[63:32];
            last_reg   <= s_tlast;
        end
        if (advance) begin
            status_reg <= sres.status;
            offset_reg <= offset_calc;
            bit_reg    <= sres.bit_idx;
            pstat_reg  <= verdict_upd;
            done_reg   <= last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {pstat_reg, bit_reg, offset_reg};
    assign m_tuser  = status_reg;
    assign m_tlast  = done_reg;

endmodule

### dv/tb_top.sv
// Self-checking testbench for the NAND page ECC corrector: random and directed chunk requests.
`timescale 1ns / 1ps

module tb_top;
    import npec_pkg::*;

    localparam int MAX_CHUNKS     = 4;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int LONG_HOLD      = 100;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [OFFS_W-1:0] offset;
        logic [BIT_W-1:0]  bit_idx;
        logic [VERD_W-1:0] verdict;
        logic              done;
    } chunk_result_t;

    typedef enum {
        CK_MATCH, CK_ECC_BIT, CK_OUTSIDE, CK_FIX, CK_BAD, CK_NOISE
    } chunk_kind_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // [31:0] computed_ecc, [63:32] stored_ecc
    logic        s_tlast;   // last_chunk
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;   // [10:0] byte_offset, [13:11] bit_index, [15:14] page_status
    logic [2:0]  m_tuser;   // [2:0] chunk_status
    logic        m_tlast;   // page_done

    chunk_result_t     pending_results[$];
    int                chunk_idx;
    logic [VERD_W-1:0] page_verdict;

    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    int rx_hold    = 0;
    int rx_gap     = 0;
    int quiet_cycles = 0;
    int mismatches   = 0;
    int requests_sent = 0;
    int pages_seen    = 0;
    int status_seen[5];

    nand_page_ecc_corrector #(
        .MAX_CHUNKS(MAX_CHUNKS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [31:0] swap_order(logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    function automatic chunk_result_t predict_chunk(logic [31:0] calc, logic [31:0] stored,
                                                    logic last);
        chunk_result_t r;
        logic [31:0] synd;
        logic [11:0] hi;
        logic [11:0] lo;
        r = '0;
        r.done = last;
        if (page_verdict == PV_UNCORR) begin
            r.status = ST_SKIPPED;
        end else if (calc != stored) begin
            synd = (swap_order(stored) ^ swap_order(calc)) & SYND_MASK;
            hi = synd[27:16];
            lo = synd[11:0];
            if ((synd & (synd - 32'd1)) == 32'd0) begin
                r.status = ST_ECC_ERR;
                if (page_verdict == PV_CLEAN) page_verdict = PV_RETRY;
            end else if ((hi ^ lo) != 12'hFFF) begin
                r.status = ST_UNCORR;
                page_verdict = PV_UNCORR;
            end else begin
                r.status  = ST_FIXED;
                r.offset  = OFFS_W'(int'(hi[11:3]) + chunk_idx * 512);
                r.bit_idx = hi[2:0];
                if (page_verdict == PV_CLEAN) page_verdict = PV_RETRY;
            end
        end
        r.verdict = page_verdict;
        if (last) begin
            chunk_idx = 0;
            page_verdict = PV_CLEAN;
        end else if (chunk_idx + 1 < MAX_CHUNKS) begin
            chunk_idx++;
        end
        return r;
    endfunction

    function automatic logic [31:0] make_diff(chunk_kind_t kind);
        logic [31:0] d;
        logic [11:0] h;
        int pos;
        d = '0;
        case (kind)
            CK_ECC_BIT: begin
                pos = $urandom_range(0, 23);
                d = 32'h1 << ((pos < 12) ? pos : pos + 4);
                if ($urandom_range(0, 1) == 1) d |= $urandom & ~SYND_MASK;
            end
            CK_OUTSIDE: begin
                d = ($urandom | 32'h0000_1000) & ~SYND_MASK;
            end
            CK_FIX: begin
                h = 12'($urandom);
                d = {4'($urandom), h, 4'($urandom), ~h};
            end
            CK_BAD: begin
                do begin
                    d = $urandom & SYND_MASK;
                end while ((d & (d - 32'd1)) == 32'd0 || (d[27:16] ^ d[11:0]) == 12'hFFF);
                d |= $urandom & ~SYND_MASK;
            end
            default: d = '0;
        endcase
        return d;
    endfunction

    function automatic chunk_kind_t pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return CK_MATCH;
        if (r < 65) return CK_FIX;
        if (r < 75) return CK_ECC_BIT;
        if (r < 80) return CK_OUTSIDE;
        if (r < 90) return CK_BAD;
        return CK_NOISE;
    endfunction

    task automatic send_chunk(input logic [31:0] calc, input logic [31:0] stored,
                              input logic last);
        int gap;
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {stored, calc};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_chunk(calc, stored, last));
        requests_sent++;
    endtask

    task automatic send_diff(input logic [31:0] diff, input logic last);
        logic [31:0] calc;
        calc = $urandom;
        send_chunk(calc, calc ^ swap_order(diff), last);
    endtask

    task automatic send_kind(input chunk_kind_t kind, input logic last);
        if (kind == CK_NOISE) send_chunk($urandom, $urandom, last);
        else send_diff(make_diff(kind), last);
    endtask

    task automatic send_page(input int len);
        for (int i = 0; i < len; i++) send_kind(pick_kind(), i == len - 1);
    endtask

    task automatic wait_results_drained();
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_chunk(32'h0000_0000, 32'h0000_0000, 1'b1);
        send_chunk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        // ecc-only errors, including differences outside the syndrome mask, then a correctable one
        send_diff(32'h0000_0001, 1'b0);
        send_diff(32'h0800_0000, 1'b0);
        send_diff(32'hF000_F000, 1'b0);
        send_diff(32'h0000_0FFF, 1'b1);
        // corrections at the top of every chunk, reaching the last page byte
        for (int i = 0; i < MAX_CHUNKS; i++) send_diff(32'h0FFF_0000, i == MAX_CHUNKS - 1);
        // abort, then skipped chunks until the page ends
        send_chunk(32'h1234_5678, 32'h1234_5678, 1'b0);
        send_diff(32'h0000_0003, 1'b0);
        send_diff(32'h0A5A_05A5, 1'b0);
        send_chunk(32'hCAFE_0000, 32'hCAFE_0000, 1'b0);
        send_diff(32'h0000_0001, 1'b1);
        // overlong page: chunk count saturates
        for (int i = 0; i < MAX_CHUNKS + 2; i++) send_diff(32'h0A5A_05A5, 1'b0);
        send_chunk(32'h0, 32'h0, 1'b1);
    endtask

    task automatic test_random_pages(input int n_items);
        int len;
        int sent;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, MAX_CHUNKS)
                                              : $urandom_range(MAX_CHUNKS + 1, MAX_CHUNKS + 3);
            send_page(len);
            sent += len;
        end
    endtask

    task automatic test_backpressure();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        rx_hold = LONG_HOLD;
        @(posedge aclk);
        tx_idle_en = 1'b0;
        test_random_pages(30);
        tx_idle_en = 1'b1;
    endtask

    task automatic test_drain_pause();
        send_page($urandom_range(1, MAX_CHUNKS));
        s_tvalid <= 1'b0;
        wait_results_drained();
        test_random_pages(20);
    endtask

    task automatic finish_run();
        s_tvalid <= 1'b0;
        wait_results_drained();
        repeat (8) @(posedge aclk);
        $display("Sent %0d chunk requests over %0d pages, with random gaps and stalls.",
                 requests_sent, pages_seen);
        $display({"Status mix: %0d match, %0d ecc-only, %0d corrected, ",
                  "%0d uncorrectable, %0d skipped."},
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
        if (mismatches == 0) begin
            $display("** nand_page_ecc_corrector: PASSED **");
        end else begin
            $display("** nand_page_ecc_corrector: FAILED **");
        end
        $finish;
    endtask

    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            m_tready <= 1'b0;
        end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
            rx_gap <= $urandom_range(0, 3);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic void check_field(string name, int unsigned expv, int unsigned act);
        if (expv != act) begin
            $error("%s: expected %0d, got %0d", name, expv, act);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        chunk_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: tuser %0d tdata %h", m_tuser, m_tdata);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("chunk_status", want.status, m_tuser);
                check_field("byte_offset", want.offset, m_tdata[10:0]);
                check_field("bit_index", want.bit_idx, m_tdata[13:11]);
                check_field("page_status", want.verdict, m_tdata[15:14]);
                check_field("page_done", want.done, m_tlast);
            end
            if (m_tuser <= ST_SKIPPED) status_seen[m_tuser]++;
            if (m_tlast) pages_seen++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no request moved for %0d cycles.", WATCHDOG_LIMIT);
            $display("** nand_page_ecc_corrector: FAILED **");
            $finish;
        end
    end

    initial begin
        chunk_idx = 0;
        page_verdict = PV_CLEAN;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random_pages(180);
        test_backpressure();
        test_drain_pause();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_random_pages(150);
        finish_run();
    end

endmodule
